// ----- rtl/bar_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bar_pkg
// Shared types, constants and register codes for the button auto-repeat unit.
// ----------------------------------------------------------------------------
package bar_pkg;

    localparam int NUM_BUTTONS = 16;
    localparam int TIME_BITS   = 32;

    localparam int BTN_W  = 16;
    localparam int NOW_W  = 32;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;
    localparam int S_DATA_W = 2 * BTN_W + NOW_W;

    localparam logic [CFG_W-1:0] DEFAULT_MASK     = 16'd511;
    localparam logic [CFG_W-1:0] DEFAULT_DELAY    = 16'd300;
    localparam logic [CFG_W-1:0] DEFAULT_INTERVAL = 16'd60;

    localparam logic [IDX_W-1:0] REG_REPEAT_MASK     = 2'd0;
    localparam logic [IDX_W-1:0] REG_REPEAT_DELAY    = 2'd1;
    localparam logic [IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd2;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef struct packed {
        logic [CFG_W-1:0] repeat_mask;
        logic [CFG_W-1:0] repeat_delay;
        logic [CFG_W-1:0] repeat_interval;
    } t_cfg;

endpackage

// ----- rtl/bar_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bar_cfg_regs
// Write-only configuration registers: repeat mask, delay and interval.
// ----------------------------------------------------------------------------
module bar_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bar_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [bar_pkg::CFG_W-1:0]  i_cfg_wdata,
    output bar_pkg::t_cfg              o_cfg
);

    bar_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.repeat_mask     <= bar_pkg::DEFAULT_MASK;
            r_cfg.repeat_delay    <= bar_pkg::DEFAULT_DELAY;
            r_cfg.repeat_interval <= bar_pkg::DEFAULT_INTERVAL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bar_pkg::REG_REPEAT_MASK:     r_cfg.repeat_mask     <= i_cfg_wdata;
                bar_pkg::REG_REPEAT_DELAY:    r_cfg.repeat_delay    <= i_cfg_wdata;
                bar_pkg::REG_REPEAT_INTERVAL: r_cfg.repeat_interval <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/bar_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bar_lane
// One button: press and fire timestamps, arm flag and the repeat decision.
// ----------------------------------------------------------------------------
module bar_lane (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic                       i_held,
    input  logic                       i_pressed,
    input  bar_pkg::t_time             i_now,
    input  logic                       i_rep_en,
    input  logic [bar_pkg::CFG_W-1:0]  i_delay,
    input  logic [bar_pkg::CFG_W-1:0]  i_interval,
    output logic                       o_eff
);

    bar_pkg::t_time r_press_time;
    bar_pkg::t_time r_fire_time;
    logic           r_armed;

    bar_pkg::t_time since_press;
    bar_pkg::t_time since_fire;
    logic           fire;

    // differences wrap modulo the time width
    assign since_press = i_now - r_press_time;
    assign since_fire  = i_now - r_fire_time;

    assign fire = i_held && !i_pressed && r_armed && i_rep_en
               && (since_press >= bar_pkg::t_time'(i_delay))
               && (since_fire  >= bar_pkg::t_time'(i_interval));

    assign o_eff = i_pressed | fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_time <= '0;
            r_fire_time  <= '0;
            r_armed      <= 1'b0;
        end else if (i_step) begin
            if (!i_held) begin
                r_armed <= 1'b0;
            end else if (i_pressed) begin
                r_press_time <= i_now;
                r_fire_time  <= i_now;
                r_armed      <= 1'b1;
            end else if (fire) begin
                r_fire_time <= i_now;
            end
        end
    end

endmodule

// ----- rtl/button_auto_repeat_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_auto_repeat_unit
// Typematic auto-repeat over a pad sample stream.
//
// Slave stream carries one pad sample per item: held mask, rising-edge mask
// and a millisecond timestamp. Master stream returns one item per sample:
// the edge mask ORed with synthetic repeat presses.
// The sample is captured in the input register, and the per-button compare
// (two wrapping subtracts and compares per button, all buttons in parallel)
// is registered into the result register when the output side advances.
// Throughput is one item per cycle while the master side accepts results,
// set by the per-button timestamp registers updating on every step.
// When the master side stalls, both stages hold and tready drops only once
// the input register is also full; nothing is lost or repeated.
// Reset clears all arm flags and timestamps and loads the default repeat
// mask, delay and interval. The configuration port is a plain write port:
// index 0 mask, 1 delay, 2 interval; other indexes are ignored.
// ----------------------------------------------------------------------------
module button_auto_repeat_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // held_buttons[15:0], pressed_buttons[31:16], now_ms[63:32]
    input  logic [bar_pkg::S_DATA_W-1:0]  i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // effective_presses[15:0]
    output logic [bar_pkg::BTN_W-1:0]     o_m_tdata,
    input  logic                          i_cfg_we,
    input  logic [bar_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [bar_pkg::CFG_W-1:0]     i_cfg_wdata
);

    bar_pkg::t_cfg cfg;

    logic                       r_in_vld;
    logic [bar_pkg::BTN_W-1:0]  r_held;
    logic [bar_pkg::BTN_W-1:0]  r_pressed;
    logic [bar_pkg::NOW_W-1:0]  r_now;
    logic                       r_out_vld;
    logic [bar_pkg::BTN_W-1:0]  r_eff;

    logic                       adv;
    logic                       step;
    logic                       in_acc;
    logic [bar_pkg::BTN_W-1:0]  eff;
    bar_pkg::t_time             now_t;

    bar_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    assign adv        = !r_out_vld || i_m_tready;
    assign step       = r_in_vld && adv;
    assign o_s_tready = !r_in_vld || adv;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign now_t      = bar_pkg::t_time'(r_now);

    for (genvar i = 0; i < bar_pkg::BTN_W; i++) begin : g_btn
        if (i < bar_pkg::NUM_BUTTONS) begin : g_lane
            bar_lane u_lane (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_step     (step),
                .i_held     (r_held[i]),
                .i_pressed  (r_pressed[i]),
                .i_now      (now_t),
                .i_rep_en   (cfg.repeat_mask[i]),
                .i_delay    (cfg.repeat_delay),
                .i_interval (cfg.repeat_interval),
                .o_eff      (eff[i])
            );
        end else begin : g_pass
            // no lane behind this bit, edges pass straight through
            assign eff[i] = r_pressed[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (step) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_held    <= i_s_tdata[bar_pkg::BTN_W-1:0];
            r_pressed <= i_s_tdata[2*bar_pkg::BTN_W-1:bar_pkg::BTN_W];
            r_now     <= i_s_tdata[bar_pkg::S_DATA_W-1:2*bar_pkg::BTN_W];
        end
        if (step) begin
            r_eff <= eff;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_eff;

    a_ready_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> o_s_tready)
        else $error("input not ready with result register empty");

    a_step_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> o_m_tvalid)
        else $error("processed item produced no result");

    a_edges_kept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> ((o_m_tdata & $past(r_pressed)) == $past(r_pressed)))
        else $error("real press edge missing from result");

    a_stalled_item_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !adv) |=> r_in_vld)
        else $error("stalled item dropped from input register");

endmodule
